// ----- hdl/rss_pkg.sv -----
// ============================================================================
// rss_pkg - shared types and constants of the relocation set selector
// Store geometry, field widths, request codes, register indexes and the
// word formats passed between the front and back parts.
// ============================================================================
package rss_pkg;

    // store and sort geometry
    localparam int MAX_PAGES   = 1024;
    localparam int PIDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W       = $clog2(MAX_PAGES + 1);
    localparam int PART_SHIFT  = 11;
    localparam int NBUCKETS    = 1 << PART_SHIFT;
    localparam int BIDX_W      = PART_SHIFT;
    localparam int AGE_CLASSES = 16;
    localparam int AGE_IW      = (AGE_CLASSES > 1) ? $clog2(AGE_CLASSES) : 1;

    // field widths
    localparam int HANDLE_W = 16;
    localparam int LIVE_W   = 40;
    localparam int SLOG_W   = 6;
    localparam int FWD_W    = 32;
    localparam int AGE_W    = 4;
    localparam int RIDX_W   = 10;
    localparam int REQ_W    = 3;
    localparam int FRAG_W   = 14;
    localparam int MODE_W   = 2;
    localparam int CIDX_W   = 2;
    localparam int TGT_W    = 21;
    localparam int OCNT_W   = 11;
    localparam int OFWD_W   = 42;
    localparam int AGEP_W   = 11;
    localparam int AGEB_W   = 50;

    // scan arithmetic
    localparam int PCT     = 100;
    localparam int PCT2    = PCT * PCT;
    localparam int SUM_W   = LIVE_W + PIDX_W;
    localparam int FSUM_W  = FWD_W + PIDX_W;
    localparam int TO_W    = SUM_W + 1;
    localparam int DTO_W   = LIVE_W + 1;
    localparam int LHS_W   = FRAG_W + CNT_W;
    localparam int RHS_W   = FRAG_W + DTO_W;

    // bus widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 200;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_SELECT   = 3'd1,
        OP_RD_ENTRY = 3'd2,
        OP_RD_AGE   = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    // register indexes and group modes
    localparam logic [CIDX_W-1:0] CFG_USABLE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAG   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEL   = 2'd1;

    // decoded request word
    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] page_handle;
        logic [LIVE_W-1:0]   live_bytes;
        logic [SLOG_W-1:0]   size_log2;
        logic [FWD_W-1:0]    forward_entries;
        logic [AGE_W-1:0]    page_age;
        logic                young_flag;
        logic [RIDX_W-1:0]   read_index;
    } item_t;

    // stored page word
    typedef struct packed {
        logic                young;
        logic [AGE_W-1:0]    age;
        logic [FWD_W-1:0]    fwd;
        logic [SLOG_W-1:0]   slog;
        logic [LIVE_W-1:0]   live;
        logic [HANDLE_W-1:0] handle;
    } page_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic                error_flag;
        logic [AGEB_W-1:0]   age_bytes;
        logic [AGEP_W-1:0]   age_pages;
        logic [OFWD_W-1:0]   forward_total;
        logic [TGT_W-1:0]    target_pages;
        logic [OCNT_W-1:0]   selected_count;
        logic                young_unselected;
        logic                is_selected;
        logic [LIVE_W-1:0]   out_live_bytes;
        logic [HANDLE_W-1:0] out_handle;
    } res_t;

endpackage

// ----- hdl/rss_front.sv -----
// ============================================================================
// rss_front - request intake
// Accepts request words, drops unknown request codes and queues the decoded
// words in a two-entry queue for the back part.
// ============================================================================
module rss_front
    import rss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output item_t                q_item
);

    localparam int QD = 2;

    item_t      q_mem_reg [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    item_t      dec;

    // unpack the bus word
    always_comb
    begin
        dec.op              = op_t'(s_tuser);
        dec.page_handle     = s_tdata[15:0];
        dec.live_bytes      = s_tdata[55:16];
        dec.size_log2       = s_tdata[61:56];
        dec.forward_entries = s_tdata[93:62];
        dec.page_age        = s_tdata[97:94];
        dec.young_flag      = s_tdata[98];
        dec.read_index      = s_tdata[108:99];
    end

    // unknown codes are taken and dropped
    assign s_tready = (cnt_reg != 2'(QD));
    assign push     = s_tvalid && s_tready && (s_tuser <= REQ_W'(OP_CLEAR));
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- hdl/rss_div.sv -----
// ============================================================================
// rss_div - sequential divider
// Restoring divider, one quotient bit per cycle, for the destination page
// count of the selection scan.
// ============================================================================
module rss_div
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [LIVE_W-1:0] divisor,
    output logic              done,
    output logic [SUM_W-1:0]  quo,
    output logic              rem_nz
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  num_reg;
    logic [LIVE_W-1:0] rem_reg;
    logic [LIVE_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [LIVE_W:0]   trial;
    logic [LIVE_W:0]   diff;
    logic              ge;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[SUM_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath, quotient shifts in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[LIVE_W-1:0] : trial[LIVE_W-1:0];
        end
    end

    assign done   = done_reg;
    assign quo    = num_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

// ----- hdl/rss_back.sv -----
// ============================================================================
// rss_back - request execution
// Holds the page store, sort order and bucket memories, the registers and
// the totals, runs the bucket sort and greedy scan sequencer and drives the
// result register.
// ============================================================================
module rss_back
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [LIVE_W-1:0] cfg_data,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output res_t              m_res
);

    typedef enum logic [21:0] {
        ST_IDLE     = 22'd1 << 0,
        ST_RD_SORT  = 22'd1 << 1,
        ST_RD_PAGE  = 22'd1 << 2,
        ST_DONE     = 22'd1 << 3,
        ST_CLR      = 22'd1 << 4,
        ST_CNT_A    = 22'd1 << 5,
        ST_CNT_B    = 22'd1 << 6,
        ST_CNT_C    = 22'd1 << 7,
        ST_PFX_A    = 22'd1 << 8,
        ST_PFX_B    = 22'd1 << 9,
        ST_PLC_A    = 22'd1 << 10,
        ST_PLC_B    = 22'd1 << 11,
        ST_PLC_C    = 22'd1 << 12,
        ST_SCN_A    = 22'd1 << 13,
        ST_SCN_B    = 22'd1 << 14,
        ST_SCN_C    = 22'd1 << 15,
        ST_SCN_DIV  = 22'd1 << 16,
        ST_SCN_SUB  = 22'd1 << 17,
        ST_SCN_MUL  = 22'd1 << 18,
        ST_SCN_CMP  = 22'd1 << 19,
        ST_FILL     = 22'd1 << 20,
        ST_SPARE    = 22'd1 << 21
    } state_t;

    localparam logic [TGT_W-1:0] TGT_MAX = '1;

    // registers
    logic [LIVE_W-1:0] usable_reg;
    logic [FRAG_W-1:0] frag_reg;
    logic [MODE_W-1:0] mode_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [CNT_W-1:0]  fing_reg, fing_next;
    logic [CNT_W-1:0]  ccnt_reg, ccnt_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [FSUM_W-1:0] cfwd_reg, cfwd_next;
    logic              unsel_reg, unsel_next;
    logic [CNT_W-1:0]  sfrom_reg, sfrom_next;
    logic [TO_W-1:0]   sto_reg, sto_next;
    logic [SUM_W-1:0]  slive_reg, slive_next;
    logic [FSUM_W-1:0] sfwd_reg, sfwd_next;

    // scan and read payload
    logic [BIDX_W-1:0] part_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [LIVE_W-1:0] cur_live_reg;
    logic [AGE_IW-1:0] cur_age_reg;
    logic [TO_W-1:0]   to_reg;
    logic [DTO_W-1:0]  dto_reg;
    logic [CNT_W-1:0]  fdiff_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic [RHS_W-1:0]  rhs_reg;
    res_t              body_reg, body;
    logic              body_ld;

    // per-age statistics
    logic [AGEP_W-1:0] age_pg_reg [AGE_CLASSES];
    logic [AGEB_W-1:0] age_by_reg [AGE_CLASSES];
    logic [AGE_IW-1:0] st_addr;
    logic [AGEP_W-1:0] st_pg;
    logic [AGEB_W-1:0] st_by;
    logic              age_clr, age_upd;

    // memories
    page_t             page_mem [MAX_PAGES];
    logic [PIDX_W-1:0] sort_mem [MAX_PAGES];
    logic [CNT_W-1:0]  bkt_mem  [NBUCKETS];
    page_t             page_q, page_wd;
    logic [PIDX_W-1:0] page_wa, page_ra;
    logic              page_we;
    logic [PIDX_W-1:0] sort_q, sort_wd, sort_wa, sort_ra;
    logic              sort_we;
    logic [CNT_W-1:0]  bkt_q, bkt_wd;
    logic [BIDX_W-1:0] bkt_wa, bkt_ra;
    logic              bkt_we;

    // divider
    logic              div_start, div_done, div_rnz;
    logic [SUM_W-1:0]  div_quo;
    logic [LIVE_W-1:0] div_dvs;

    // output
    logic              out_vld_reg;
    res_t              out_res_reg, res;
    logic              out_free, emit;

    logic              keep_ok;
    logic [FRAG_W-1:0] keep_w;
    logic [TO_W-1:0]   dto_raw;

    function automatic logic [BIDX_W-1:0] part_of(page_t p);
        logic [SLOG_W-1:0] sh;
        logic [LIVE_W-1:0] v;
        sh = (p.slog > SLOG_W'(PART_SHIFT)) ? p.slog - SLOG_W'(PART_SHIFT) : '0;
        v  = p.live >> sh;
        part_of = (v > LIVE_W'(NBUCKETS - 1)) ? BIDX_W'(NBUCKETS - 1) : v[BIDX_W-1:0];
    endfunction

    assign out_free = !out_vld_reg || m_ready;
    assign keep_ok  = (frag_reg <= FRAG_W'(PCT2));
    assign keep_w   = FRAG_W'(PCT2) - frag_reg;
    assign div_dvs  = (usable_reg == '0) ? LIVE_W'(1) : usable_reg;
    assign dto_raw  = to_reg - sto_reg;

    // age statistics read port
    assign st_addr = (state_reg == ST_SCN_CMP) ? cur_age_reg : AGE_IW'(q_item.read_index);
    assign st_pg   = age_pg_reg[st_addr];
    assign st_by   = age_by_reg[st_addr];

    rss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (slive_next),
        .divisor  (div_dvs),
        .done     (div_done),
        .quo      (div_quo),
        .rem_nz   (div_rnz)
    );

    // page word from the request
    always_comb
    begin
        page_wd.young  = q_item.young_flag;
        page_wd.age    = q_item.page_age;
        page_wd.fwd    = q_item.forward_entries;
        page_wd.slog   = q_item.size_log2;
        page_wd.live   = q_item.live_bytes;
        page_wd.handle = q_item.page_handle;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        bidx_next  = bidx_reg;
        fing_next  = fing_reg;
        ccnt_next  = ccnt_reg;
        tgt_next   = tgt_reg;
        cfwd_next  = cfwd_reg;
        unsel_next = unsel_reg;
        sfrom_next = sfrom_reg;
        sto_next   = sto_reg;
        slive_next = slive_reg;
        sfwd_next  = sfwd_reg;
        q_ready    = 1'b0;
        emit       = 1'b0;
        body       = body_reg;
        body_ld    = 1'b0;
        page_we    = 1'b0;
        page_wa    = pc_reg[PIDX_W-1:0];
        page_ra    = idx_reg[PIDX_W-1:0];
        sort_we    = 1'b0;
        sort_wa    = pc_reg[PIDX_W-1:0];
        sort_wd    = pc_reg[PIDX_W-1:0];
        sort_ra    = idx_reg[PIDX_W-1:0];
        bkt_we     = 1'b0;
        bkt_wa     = bidx_reg;
        bkt_wd     = '0;
        bkt_ra     = bidx_reg;
        div_start  = 1'b0;
        age_clr    = 1'b0;
        age_upd    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                body    = '0;
                sort_ra = PIDX_W'(q_item.read_index);
                if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    case (q_item.op)
                        OP_APPEND:
                        begin
                            emit = 1'b1;
                            if (pc_reg == CNT_W'(MAX_PAGES))
                            begin
                                body.error_flag = 1'b1;
                            end
                            else
                            begin
                                page_we = 1'b1;
                                sort_we = 1'b1;
                                pc_next = pc_reg + 1'b1;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (mode_reg == MODE_OFF)
                            begin
                                emit = 1'b1;
                            end
                            else if (mode_reg == MODE_SEL)
                            begin
                                age_clr    = 1'b1;
                                cfwd_next  = '0;
                                bidx_next  = '0;
                                state_next = ST_CLR;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_FILL;
                            end
                        end
                        OP_RD_ENTRY:
                        begin
                            if (32'(q_item.read_index) >= 32'(pc_reg))
                            begin
                                emit            = 1'b1;
                                body.error_flag = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RD_SORT;
                            end
                        end
                        OP_RD_AGE:
                        begin
                            emit = 1'b1;
                            if (32'(q_item.read_index) >= AGE_CLASSES)
                            begin
                                body.error_flag = 1'b1;
                            end
                            else
                            begin
                                body.age_pages = st_pg;
                                body.age_bytes = st_by;
                            end
                        end
                        OP_CLEAR:
                        begin
                            emit       = 1'b1;
                            pc_next    = '0;
                            ccnt_next  = '0;
                            tgt_next   = '0;
                            cfwd_next  = '0;
                            unsel_next = 1'b0;
                            age_clr    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // sorted entry read: order memory, then page memory
            ST_RD_SORT:
            begin
                page_ra    = sort_q;
                state_next = ST_RD_PAGE;
            end
            ST_RD_PAGE:
            begin
                body                  = '0;
                body_ld               = 1'b1;
                body.out_handle       = page_q.handle;
                body.out_live_bytes   = page_q.live;
                body.is_selected      = (32'(ridx_reg) < 32'(ccnt_reg));
                body.young_unselected = unsel_reg ||
                                        (!(32'(ridx_reg) < 32'(ccnt_reg)) && page_q.young);
                state_next            = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // bucket clearing pass
            ST_CLR:
            begin
                bkt_we    = 1'b1;
                bidx_next = bidx_reg + 1'b1;
                if (bidx_reg == BIDX_W'(NBUCKETS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_CNT_A;
                end
            end

            // bucket histogram
            ST_CNT_A:
            begin
                if (idx_reg == pc_reg)
                begin
                    bidx_next  = '0;
                    fing_next  = '0;
                    state_next = ST_PFX_A;
                end
                else
                begin
                    state_next = ST_CNT_B;
                end
            end
            ST_CNT_B:
            begin
                bkt_ra     = part_of(page_q);
                state_next = ST_CNT_C;
            end
            ST_CNT_C:
            begin
                bkt_we     = 1'b1;
                bkt_wa     = part_reg;
                bkt_wd     = bkt_q + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_CNT_A;
            end

            // exclusive prefix sum over the buckets
            ST_PFX_A:
            begin
                state_next = ST_PFX_B;
            end
            ST_PFX_B:
            begin
                bkt_we    = 1'b1;
                bkt_wd    = fing_reg;
                fing_next = fing_reg + bkt_q;
                if (bidx_reg == BIDX_W'(NBUCKETS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_PLC_A;
                end
                else
                begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = ST_PFX_A;
                end
            end

            // stable placement into the order memory
            ST_PLC_A:
            begin
                if (idx_reg == pc_reg)
                begin
                    idx_next   = '0;
                    sfrom_next = '0;
                    sto_next   = '0;
                    slive_next = '0;
                    sfwd_next  = '0;
                    state_next = ST_SCN_A;
                end
                else
                begin
                    state_next = ST_PLC_B;
                end
            end
            ST_PLC_B:
            begin
                bkt_ra     = part_of(page_q);
                state_next = ST_PLC_C;
            end
            ST_PLC_C:
            begin
                bkt_we = 1'b1;
                bkt_wa = part_reg;
                bkt_wd = bkt_q + 1'b1;
                if (32'(bkt_q) < MAX_PAGES)
                begin
                    sort_we = 1'b1;
                    sort_wa = PIDX_W'(bkt_q);
                    sort_wd = idx_reg[PIDX_W-1:0];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_PLC_A;
            end

            // greedy scan, one sorted page per pass
            ST_SCN_A:
            begin
                if (idx_reg == pc_reg)
                begin
                    ccnt_next  = sfrom_reg;
                    tgt_next   = (sto_reg > TO_W'(TGT_MAX)) ? TGT_MAX : sto_reg[TGT_W-1:0];
                    unsel_next = 1'b0;
                    body       = '0;
                    body_ld    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCN_B;
                end
            end
            ST_SCN_B:
            begin
                page_ra    = sort_q;
                state_next = ST_SCN_C;
            end
            ST_SCN_C:
            begin
                slive_next = slive_reg + SUM_W'(page_q.live);
                sfwd_next  = sfwd_reg + FSUM_W'(page_q.fwd);
                div_start  = 1'b1;
                state_next = ST_SCN_DIV;
            end
            ST_SCN_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCN_SUB;
                end
            end
            ST_SCN_SUB:
            begin
                state_next = ST_SCN_MUL;
            end
            ST_SCN_MUL:
            begin
                state_next = ST_SCN_CMP;
            end
            ST_SCN_CMP:
            begin
                if (keep_ok && (RHS_W'(lhs_reg) > rhs_reg))
                begin
                    sfrom_next = idx_reg + 1'b1;
                    sto_next   = to_reg;
                    cfwd_next  = sfwd_reg;
                    age_upd    = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SCN_A;
            end

            // not selectable: order back to append order
            ST_FILL:
            begin
                if (idx_reg == pc_reg)
                begin
                    ccnt_next  = '0;
                    tgt_next   = '0;
                    cfwd_next  = '0;
                    unsel_next = 1'b1;
                    body       = '0;
                    body_ld    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    sort_we  = 1'b1;
                    sort_wa  = idx_reg[PIDX_W-1:0];
                    sort_wd  = idx_reg[PIDX_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word with the totals as they stand after this cycle
    always_comb
    begin
        res                = body;
        res.selected_count = OCNT_W'(ccnt_next);
        res.target_pages   = tgt_next;
        res.forward_total  = OFWD_W'(cfwd_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg  <= LIVE_W'(2097152);
            frag_reg    <= FRAG_W'(2500);
            mode_reg    <= MODE_SEL;
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            idx_reg     <= '0;
            bidx_reg    <= '0;
            fing_reg    <= '0;
            ccnt_reg    <= '0;
            tgt_reg     <= '0;
            cfwd_reg    <= '0;
            unsel_reg   <= 1'b0;
            sfrom_reg   <= '0;
            sto_reg     <= '0;
            slive_reg   <= '0;
            sfwd_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_USABLE: usable_reg <= cfg_data;
                    CFG_FRAG:   frag_reg   <= cfg_data[FRAG_W-1:0];
                    CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg <= state_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            bidx_reg  <= bidx_next;
            fing_reg  <= fing_next;
            ccnt_reg  <= ccnt_next;
            tgt_reg   <= tgt_next;
            cfwd_reg  <= cfwd_next;
            unsel_reg <= unsel_next;
            sfrom_reg <= sfrom_next;
            sto_reg   <= sto_next;
            slive_reg <= slive_next;
            sfwd_reg  <= sfwd_next;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // age statistics, cleared together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AGE_CLASSES; a++)
            begin
                age_pg_reg[a] <= '0;
                age_by_reg[a] <= '0;
            end
        end
        else if (age_clr)
        begin
            for (int a = 0; a < AGE_CLASSES; a++)
            begin
                age_pg_reg[a] <= '0;
                age_by_reg[a] <= '0;
            end
        end
        else if (age_upd)
        begin
            age_pg_reg[cur_age_reg] <= st_pg + 1'b1;
            age_by_reg[cur_age_reg] <= st_by + AGEB_W'(cur_live_reg);
        end
    end

    // payload registers and the scan datapath
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_res_reg <= res;
        end
        if (body_ld)
        begin
            body_reg <= body;
        end
        if (state_reg == ST_IDLE)
        begin
            ridx_reg <= q_item.read_index;
        end
        if ((state_reg == ST_CNT_B) || (state_reg == ST_PLC_B))
        begin
            part_reg <= part_of(page_q);
        end
        if (state_reg == ST_SCN_C)
        begin
            cur_live_reg <= page_q.live;
            cur_age_reg  <= (32'(page_q.age) >= AGE_CLASSES) ?
                            AGE_IW'(AGE_CLASSES - 1) : AGE_IW'(page_q.age);
        end
        if ((state_reg == ST_SCN_DIV) && div_done)
        begin
            to_reg <= TO_W'(div_quo) + TO_W'(div_rnz);
        end
        if (state_reg == ST_SCN_SUB)
        begin
            dto_reg   <= (dto_raw > (TO_W'(1) << LIVE_W)) ?
                         (DTO_W'(1) << LIVE_W) : dto_raw[DTO_W-1:0];
            fdiff_reg <= idx_reg + 1'b1 - sfrom_reg;
        end
        if (state_reg == ST_SCN_MUL)
        begin
            lhs_reg <= LHS_W'(keep_w) * LHS_W'(fdiff_reg);
            rhs_reg <= RHS_W'(PCT2) * RHS_W'(dto_reg);
        end
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_wa] <= page_wd;
        end
        page_q <= page_mem[page_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[sort_wa] <= sort_wd;
        end
        sort_q <= sort_mem[sort_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        bkt_q <= bkt_mem[bkt_ra];
    end

    assign m_valid = out_vld_reg;
    assign m_res   = out_res_reg;

endmodule

// ----- hdl/relocation_set_selector.sv -----
// ============================================================================
// relocation_set_selector - relocation set selection for one page group
// Loads pages, sorts them by live bytes, picks the relocation prefix and
// answers read requests for entries, totals and per-age statistics.
// ============================================================================
// Append, age read, clear and a select in disabled mode are each answered
// from the idle state and can follow one another every cycle while the
// result output is free; a sorted entry read passes through order memory
// read, page memory read and result. A select in not-selectable mode
// rewrites the order memory page by page. A select in selectable mode walks
// the pages through a sequencer: it clears the bucket memory, counts the
// pages into buckets, forms the bucket prefix sum, places the pages and
// scans them, with a bit-serial divider for the destination page count in
// each scan step. Configuration writes are always ready; the user must keep
// them to idle periods, the block itself does not enforce this.
module relocation_set_selector
    import rss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // page_handle[15:0], live_bytes[55:16], size_log2[61:56],
    // forward_entries[93:62], page_age[97:94], young_flag[98],
    // read_index[108:99], zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]     s_tuser,
    // out_handle[15:0], out_live_bytes[55:16], is_selected[56],
    // young_unselected[57], selected_count[68:58], target_pages[89:69],
    // forward_total[131:90], age_pages[142:132], age_bytes[192:143],
    // error_flag[193], zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [LIVE_W-1:0]    cfg_data
);

    logic  q_valid, q_ready;
    item_t q_item;
    res_t  res;

    assign cfg_ready = 1'b1;

    rss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    rss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    assign m_tdata = {(M_TDATA_W - $bits(res_t))'(0), res};

    // the prefix never outgrows the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(res.selected_count) <= MAX_PAGES))
        else $error("selected count above store depth");

    // an empty prefix needs no destination pages
    a_empty_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res.selected_count == '0)) |-> (res.target_pages == '0))
        else $error("targets without selected pages");

    // a selected entry is never in the unselected young list
    a_sel_young: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.is_selected) |-> !res.young_unselected)
        else $error("selected entry flagged young unselected");

endmodule
